// File: design/modulated_feedback_delay_defines.svh
// Assertion macros shared by the checker of the modulated feedback delay.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MODULATED_FEEDBACK_DELAY_DEFINES_SVH
`define MODULATED_FEEDBACK_DELAY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mfd_pkg.sv
package mfd_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int PHASE_W    = 16;
	localparam int AMP_W      = 13;
	localparam int OFFSET_W   = 17;
	localparam int BASE_W     = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int STEP_W     = 5;

	localparam int GAIN_ONE  = 32768;
	localparam int BASE_MAX  = 131072;
	localparam int SWING_MAX = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_ENABLE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_PERIOD      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_AMPLITUDE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_BASE        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN   = 3'd6;

	localparam logic [OFFSET_W-1:0]     RST_DELAY_OFFSET  = 17'd80000;
	localparam logic [PHASE_W-1:0]      RST_MOD_PERIOD    = 16'd25000;
	localparam logic signed [AMP_W-1:0] RST_MOD_AMPLITUDE = 13'sd20;
	localparam logic [BASE_W-1:0]       RST_MOD_BASE      = 18'd50;
	localparam logic [GAIN_W-1:0]       RST_MIX_GAIN      = 16'd9830;
	localparam logic [GAIN_W-1:0]       RST_FEEDBACK_GAIN = 16'd16384;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [STEP_W-1:0] {
		ST_IDLE,
		ST_CHK_OFS,
		ST_OFS_LOAD,
		ST_OFS_RED,
		ST_OFS_SET,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_MUL_DFB,
		ST_MUL_XFB,
		ST_MUL_DMX,
		ST_MUL_XMX,
		ST_OUT,
		ST_CHK_MOD,
		ST_PH_MUL,
		ST_DIV,
		ST_ROM,
		ST_SWING,
		ST_MOD_LOAD,
		ST_MOD_RED,
		ST_MOD_SET
	} step_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_NOP,
		OP_RED_OFS,
		OP_RED_STEP,
		OP_OFS_SET,
		OP_RD_ADDR,
		OP_RD_MEM,
		OP_MUL_DFB,
		OP_MUL_XFB,
		OP_MUL_DMX,
		OP_MUL_XMX,
		OP_OUT,
		OP_PH_MUL,
		OP_DIV_STEP,
		OP_ROM,
		OP_SWING,
		OP_RED_MOD,
		OP_MOD_SET
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_WAIT_IN,
		COND_CLEAN,
		COND_LOOP,
		COND_OUT_BUSY,
		COND_MOD_OFF
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic dirty;
		logic loop_last;
		logic out_busy;
		logic mod_en;
	} seq_stat_t;

	// Truncating division by 2^15, rounding toward zero.
	function automatic logic signed [26:0] trz15(input logic signed [41:0] p);
		logic signed [41:0] t;
		t = p[41] ? p + 42'sd32767 : p;
		return 27'(t >>> 15);
	endfunction

	// Sine of a Q34.30 angle in [0, 2*pi): sign bit on top, Q1.30 magnitude below.
	function automatic logic [31:0] sine_word(input logic [63:0] ang);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic        neg;
		x   = ang;
		neg = 1'b0;
		if (x > PI_Q30) begin
			neg = 1'b1;
			x   = x - PI_Q30;
		end
		if (x > HALF_PI_Q30) begin
			x = (x > PI_Q30) ? 64'd0 : PI_Q30 - x;
		end
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 64'd110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		return {neg, 31'((x * t) >> 30)};
	endfunction

endpackage

// File: design/mfd_if.sv
interface mfd_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mfd_pkg::SAMPLE_W-1:0]   sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface mfd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [mfd_pkg::SAMPLE_W-1:0]   sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

interface mfd_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [mfd_pkg::CFG_IDX_W-1:0]         index;
	logic [mfd_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/mfd_seq.sv
module mfd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  mfd_pkg::seq_stat_t stat,
	output mfd_pkg::uword_t    uword
);

	mfd_pkg::step_t pc_q;
	mfd_pkg::step_t pc_d;
	mfd_pkg::step_t pc_inc;

	function automatic mfd_pkg::uword_t ucode(input mfd_pkg::step_t s);
		mfd_pkg::uword_t u;
		case (s)
			mfd_pkg::ST_IDLE:     u = '{mfd_pkg::OP_IDLE, mfd_pkg::COND_WAIT_IN, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_CHK_OFS:  u = '{mfd_pkg::OP_NOP, mfd_pkg::COND_CLEAN, mfd_pkg::ST_RD_ADDR};
			mfd_pkg::ST_OFS_LOAD: u = '{mfd_pkg::OP_RED_OFS, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_OFS_RED:  u = '{mfd_pkg::OP_RED_STEP, mfd_pkg::COND_LOOP, mfd_pkg::ST_OFS_RED};
			mfd_pkg::ST_OFS_SET:  u = '{mfd_pkg::OP_OFS_SET, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_RD_ADDR:  u = '{mfd_pkg::OP_RD_ADDR, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_RD_MEM:   u = '{mfd_pkg::OP_RD_MEM, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MUL_DFB:  u = '{mfd_pkg::OP_MUL_DFB, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MUL_XFB:  u = '{mfd_pkg::OP_MUL_XFB, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MUL_DMX:  u = '{mfd_pkg::OP_MUL_DMX, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MUL_XMX:  u = '{mfd_pkg::OP_MUL_XMX, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_OUT:      u = '{mfd_pkg::OP_OUT, mfd_pkg::COND_OUT_BUSY, mfd_pkg::ST_OUT};
			mfd_pkg::ST_CHK_MOD:  u = '{mfd_pkg::OP_NOP, mfd_pkg::COND_MOD_OFF, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_PH_MUL:   u = '{mfd_pkg::OP_PH_MUL, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_DIV:      u = '{mfd_pkg::OP_DIV_STEP, mfd_pkg::COND_LOOP, mfd_pkg::ST_DIV};
			mfd_pkg::ST_ROM:      u = '{mfd_pkg::OP_ROM, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_SWING:    u = '{mfd_pkg::OP_SWING, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MOD_LOAD: u = '{mfd_pkg::OP_RED_MOD, mfd_pkg::COND_NEXT, mfd_pkg::ST_IDLE};
			mfd_pkg::ST_MOD_RED:  u = '{mfd_pkg::OP_RED_STEP, mfd_pkg::COND_LOOP, mfd_pkg::ST_MOD_RED};
			mfd_pkg::ST_MOD_SET:  u = '{mfd_pkg::OP_MOD_SET, mfd_pkg::COND_JUMP, mfd_pkg::ST_IDLE};
			default:              u = '{mfd_pkg::OP_NOP, mfd_pkg::COND_JUMP, mfd_pkg::ST_IDLE};
		endcase
		return u;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mfd_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		uword = ucode(pc_q);
	end

	always_comb begin
		pc_inc = mfd_pkg::step_t'(mfd_pkg::STEP_W'(pc_q) + mfd_pkg::STEP_W'(1));
		case (uword.cond)
			mfd_pkg::COND_NEXT:     pc_d = pc_inc;
			mfd_pkg::COND_JUMP:     pc_d = uword.target;
			mfd_pkg::COND_WAIT_IN:  pc_d = stat.in_valid ? pc_inc : uword.target;
			mfd_pkg::COND_CLEAN:    pc_d = stat.dirty ? pc_inc : uword.target;
			mfd_pkg::COND_LOOP:     pc_d = stat.loop_last ? pc_inc : uword.target;
			mfd_pkg::COND_OUT_BUSY: pc_d = stat.out_busy ? uword.target : pc_inc;
			mfd_pkg::COND_MOD_OFF:  pc_d = stat.mod_en ? pc_inc : uword.target;
			default:                pc_d = mfd_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: design/modulated_feedback_delay.sv
// Modulated feedback delay line for 24-bit audio samples.
// sample_ch carries one signed sample per item into the block and result_ch carries
// one mixed sample per item out; both complete an item when valid and ready are high.
// cfg writes one of the seven registers by index; writes to unknown indexes are dropped.
// sample_ch.ready and cfg.ready are high only while the sequencer waits at its idle step.
// An accepted input passes the read-address, store-read, multiply and output steps in that order.
// The block takes no new item before it is back at its idle step. With modulation off
// it returns there after the output step; with modulation on it first runs the
// serial phase divider, whose length is DW = 16 + clog2(SINE_STEPS) steps, and then the
// offset reduction unit with NSH shift-subtract steps (2 at the default store length).
// The first item after a delay_offset write also passes the offset reduction steps.
// Reset clears the write pointer and the phase counter and returns the registers to their defaults.
// The sample store is not swept: a write pointer and a wrap flag track which slots were
// written, and a slot never written reads as zero.
// A stalled receiver holds the result in the output register; the sequencer waits at
// its output step only when a second result is ready before the first was taken.
module modulated_feedback_delay #(
	parameter int unsigned STORE_LENGTH = 131072,
	parameter int unsigned SINE_STEPS   = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	mfd_in_if.sink    sample_ch,
	mfd_out_if.source result_ch,
	mfd_cfg_if.sink   cfg
);

	localparam int AW      = $clog2(STORE_LENGTH);
	localparam int KW      = $clog2(SINE_STEPS);
	localparam int DW      = mfd_pkg::PHASE_W + KW;
	localparam int CW      = $clog2(DW + 1);
	localparam int MODOFF  = STORE_LENGTH *
		((mfd_pkg::BASE_MAX + mfd_pkg::SWING_MAX + STORE_LENGTH - 1) / STORE_LENGTH);
	localparam int MAXU    = STORE_LENGTH + mfd_pkg::SWING_MAX + MODOFF;
	localparam int MW      = $clog2(MAXU + 1);
	localparam int NSH     = $clog2((MAXU / STORE_LENGTH) + 1);
	localparam int DVW     = MW + 1;

	localparam logic [DVW-1:0] DV_INIT = DVW'(STORE_LENGTH * (2 ** (NSH - 1)));
	localparam logic [MW-1:0]  U_BASE  = MW'(STORE_LENGTH + MODOFF);
	localparam logic [AW:0]    LEN_X   = (AW + 1)'(STORE_LENGTH);
	localparam logic [AW-1:0]  WP_LAST = AW'(STORE_LENGTH - 1);
	localparam logic [KW:0]    S_K     = (KW + 1)'(SINE_STEPS);
	localparam logic [DW-1:0]  S_D     = DW'(SINE_STEPS);

	mfd_pkg::uword_t    uw;
	mfd_pkg::seq_stat_t stat;
	mfd_pkg::op_t       op;

	logic [mfd_pkg::OFFSET_W-1:0]      dly_raw_q;
	logic                              mod_en_q;
	logic [mfd_pkg::PHASE_W-1:0]       per_q;
	logic signed [mfd_pkg::AMP_W-1:0]  amp_q;
	logic [mfd_pkg::BASE_W-1:0]        base_q;
	logic [mfd_pkg::GAIN_W-1:0]        mix_q;
	logic [mfd_pkg::GAIN_W-1:0]        fb_q;
	logic                              dirty_q;

	logic [AW-1:0]                     active_off_q;
	logic [AW-1:0]                     wp_q;
	logic                              wrapped_q;
	logic [mfd_pkg::PHASE_W-1:0]       phase_q;
	logic                              out_valid_q;
	logic [CW-1:0]                     cnt_q;

	logic signed [mfd_pkg::SAMPLE_W-1:0] x_q;
	logic [AW-1:0]                       rd_q;
	logic signed [mfd_pkg::SAMPLE_W-1:0] rdata_q;
	logic                                vld_q;
	logic signed [40:0]                  prod_q;
	logic signed [41:0]                  acc_q;
	logic signed [mfd_pkg::SAMPLE_W-1:0] y_q;
	logic [MW-1:0]                       red_q;
	logic [DVW-1:0]                      dv_q;
	logic [DW-1:0]                       num_q;
	logic [mfd_pkg::PHASE_W-1:0]         rem_q;
	logic [KW-1:0]                       qm_q;
	logic [31:0]                         sine_q;
	logic [43:0]                         swp_q;
	logic                                swneg_q;

	logic signed [mfd_pkg::SAMPLE_W-1:0] store_mem [STORE_LENGTH];
	logic [31:0]                         sine_rom [SINE_STEPS];

	logic                              idle;
	logic                              in_acc;
	logic                              cfg_acc;
	logic                              out_busy;
	logic [mfd_pkg::GAIN_W-1:0]        fb_eff;
	logic [mfd_pkg::GAIN_W-1:0]        mx_eff;
	logic [mfd_pkg::PHASE_W:0]         per17;
	logic [mfd_pkg::PHASE_W:0]         ph_inc;
	logic signed [mfd_pkg::SAMPLE_W-1:0] d_val;
	logic signed [mfd_pkg::SAMPLE_W-1:0] mul_a;
	logic signed [16:0]                mul_b;
	logic signed [40:0]                mul_p;
	logic signed [41:0]                wr_sum;
	logic [AW:0]                       rd_sum;
	logic [mfd_pkg::PHASE_W:0]         div_t;
	logic                              div_ge;
	logic [KW:0]                       q2;
	logic [DVW-1:0]                    red_x;
	logic [mfd_pkg::AMP_W-1:0]         amag;
	logic [MW-1:0]                     sw_mw;
	logic [MW-1:0]                     u_val;

	for (genvar g = 0; g < SINE_STEPS; g++) begin : g_sine
		localparam logic [63:0] ANG = (64'(g) * mfd_pkg::TWO_PI_Q30) / 64'(SINE_STEPS);
		assign sine_rom[g] = mfd_pkg::sine_word(ANG);
	end

	mfd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uword  (uw)
	);

	assign op       = uw.op;
	assign idle     = (op == mfd_pkg::OP_IDLE);
	assign in_acc   = idle && sample_ch.valid;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign out_busy = out_valid_q && !result_ch.ready;

	assign sample_ch.ready      = idle;
	assign cfg.ready            = idle;
	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = y_q;

	assign stat.in_valid  = sample_ch.valid;
	assign stat.dirty     = dirty_q;
	assign stat.loop_last = (cnt_q == CW'(1));
	assign stat.out_busy  = out_busy;
	assign stat.mod_en    = mod_en_q;

	always_comb begin
		fb_eff = (fb_q > 16'(mfd_pkg::GAIN_ONE)) ? 16'(mfd_pkg::GAIN_ONE) : fb_q;
		mx_eff = (mix_q > 16'(mfd_pkg::GAIN_ONE)) ? 16'(mfd_pkg::GAIN_ONE) : mix_q;
		per17  = {1'b0, (per_q == '0) ? 16'd1 : per_q};
		ph_inc = {1'b0, phase_q} + 17'd1;
		d_val  = vld_q ? rdata_q : '0;

		case (op)
			mfd_pkg::OP_MUL_DFB: begin
				mul_a = d_val;
				mul_b = 17'({1'b0, fb_eff});
			end
			mfd_pkg::OP_MUL_XFB: begin
				mul_a = x_q;
				mul_b = 17'({1'b0, 16'(mfd_pkg::GAIN_ONE) - fb_eff});
			end
			mfd_pkg::OP_MUL_DMX: begin
				mul_a = d_val;
				mul_b = 17'({1'b0, mx_eff});
			end
			default: begin
				mul_a = x_q;
				mul_b = 17'({1'b0, 16'(mfd_pkg::GAIN_ONE) - mx_eff});
			end
		endcase
		mul_p  = mul_a * mul_b;
		wr_sum = acc_q + 42'(mfd_pkg::trz15(42'(prod_q)));

		rd_sum = {1'b0, wp_q} + {1'b0, active_off_q};

		div_t  = {rem_q, num_q[DW-1]};
		div_ge = (div_t >= per17);
		q2     = {qm_q, div_ge};

		red_x  = {1'b0, red_q};

		amag   = amp_q[mfd_pkg::AMP_W-1] ? 13'(-amp_q) : 13'(amp_q);
		sw_mw  = MW'(swp_q[42:30]);
		u_val  = U_BASE - MW'(base_q) + (swneg_q ? -sw_mw : sw_mw);
	end

	// Configuration registers and sequencer-owned control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_raw_q    <= mfd_pkg::RST_DELAY_OFFSET;
			mod_en_q     <= 1'b0;
			per_q        <= mfd_pkg::RST_MOD_PERIOD;
			amp_q        <= mfd_pkg::RST_MOD_AMPLITUDE;
			base_q       <= mfd_pkg::RST_MOD_BASE;
			mix_q        <= mfd_pkg::RST_MIX_GAIN;
			fb_q         <= mfd_pkg::RST_FEEDBACK_GAIN;
			dirty_q      <= 1'b1;
			active_off_q <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			phase_q      <= '0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_acc) begin
				case (cfg.index)
					mfd_pkg::REG_DELAY_OFFSET: begin
						dly_raw_q <= cfg.data[mfd_pkg::OFFSET_W-1:0];
						dirty_q   <= 1'b1;
					end
					mfd_pkg::REG_MOD_ENABLE:    mod_en_q <= cfg.data[0];
					mfd_pkg::REG_MOD_PERIOD:    per_q    <= cfg.data[mfd_pkg::PHASE_W-1:0];
					mfd_pkg::REG_MOD_AMPLITUDE: amp_q    <= signed'(cfg.data[mfd_pkg::AMP_W-1:0]);
					mfd_pkg::REG_MOD_BASE:      base_q   <= cfg.data[mfd_pkg::BASE_W-1:0];
					mfd_pkg::REG_MIX_GAIN:      mix_q    <= cfg.data[mfd_pkg::GAIN_W-1:0];
					mfd_pkg::REG_FEEDBACK_GAIN: fb_q     <= cfg.data[mfd_pkg::GAIN_W-1:0];
					default: begin
					end
				endcase
			end

			if (op == mfd_pkg::OP_OUT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (op)
				mfd_pkg::OP_RED_OFS: cnt_q <= CW'(NSH);
				mfd_pkg::OP_RED_MOD: cnt_q <= CW'(NSH);
				mfd_pkg::OP_PH_MUL:  cnt_q <= CW'(DW);
				mfd_pkg::OP_RED_STEP: cnt_q <= cnt_q - CW'(1);
				mfd_pkg::OP_DIV_STEP: cnt_q <= cnt_q - CW'(1);
				mfd_pkg::OP_OFS_SET: begin
					active_off_q <= red_q[AW-1:0];
					dirty_q      <= 1'b0;
				end
				mfd_pkg::OP_OUT: begin
					if (!out_busy) begin
						if (wp_q == WP_LAST) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
					end
				end
				mfd_pkg::OP_MOD_SET: begin
					active_off_q <= red_q[AW-1:0];
					phase_q      <= (ph_inc >= per17) ? '0 : ph_inc[mfd_pkg::PHASE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_ch.sample_in;
		end
		case (op)
			mfd_pkg::OP_RED_OFS: begin
				red_q <= MW'(dly_raw_q);
				dv_q  <= DV_INIT;
			end
			mfd_pkg::OP_RED_MOD: begin
				red_q <= u_val;
				dv_q  <= DV_INIT;
			end
			mfd_pkg::OP_RED_STEP: begin
				if (red_x >= dv_q) begin
					red_q <= MW'(red_x - dv_q);
				end
				dv_q <= dv_q >> 1;
			end
			mfd_pkg::OP_RD_ADDR: begin
				rd_q <= (rd_sum >= LEN_X) ? AW'(rd_sum - LEN_X) : rd_sum[AW-1:0];
			end
			mfd_pkg::OP_RD_MEM: begin
				vld_q <= wrapped_q || (rd_q < wp_q);
			end
			mfd_pkg::OP_MUL_DFB: begin
				prod_q <= mul_p;
			end
			mfd_pkg::OP_MUL_XFB: begin
				prod_q <= mul_p;
				acc_q  <= 42'(mfd_pkg::trz15(42'(prod_q)));
			end
			mfd_pkg::OP_MUL_DMX: begin
				prod_q <= mul_p;
			end
			mfd_pkg::OP_MUL_XMX: begin
				prod_q <= mul_p;
				acc_q  <= 42'(prod_q);
			end
			mfd_pkg::OP_OUT: begin
				if (!out_busy) begin
					y_q <= mfd_pkg::SAMPLE_W'(mfd_pkg::trz15(acc_q + 42'(prod_q)));
				end
			end
			mfd_pkg::OP_PH_MUL: begin
				num_q <= DW'(phase_q) * S_D;
				rem_q <= '0;
				qm_q  <= '0;
			end
			mfd_pkg::OP_DIV_STEP: begin
				rem_q <= div_ge ? 16'(div_t - per17) : div_t[mfd_pkg::PHASE_W-1:0];
				num_q <= num_q << 1;
				qm_q  <= (q2 >= S_K) ? KW'(q2 - S_K) : q2[KW-1:0];
			end
			mfd_pkg::OP_ROM: begin
				sine_q <= sine_rom[qm_q];
			end
			mfd_pkg::OP_SWING: begin
				swp_q   <= 44'(amag) * 44'(sine_q[30:0]);
				swneg_q <= amp_q[mfd_pkg::AMP_W-1] ^ sine_q[31];
			end
			default: begin
			end
		endcase
	end

	// Sample store: one read and one write port, registered read.
	always_ff @(posedge clk) begin
		if (op == mfd_pkg::OP_MUL_DMX) begin
			store_mem[wp_q] <= wr_sum[mfd_pkg::SAMPLE_W-1:0];
		end
		if (op == mfd_pkg::OP_RD_MEM) begin
			rdata_q <= store_mem[rd_q];
		end
	end

endmodule

// File: design/mfd_checker.sv
`include "modulated_feedback_delay_defines.svh"

module mfd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                cfg_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [mfd_pkg::SAMPLE_W-1:0] sample_out
);

	`MFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MFD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sample_out), "result changed while stalled")
	`MFD_ASSERT_NOW(a_ready_match, 1'b1, in_ready == cfg_ready, "sample and config ready disagree")
	`MFD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !cfg_ready, "block idle after an accepted item")

endmodule

bind modulated_feedback_delay mfd_checker u_mfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.cfg_ready  (cfg.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.sample_out (result_ch.sample_out)
);
